// ===== hw/rtl/rfop_pkg.sv =====
// Shared types, constants and helpers for the ring FIFO with overrun policy.
`timescale 1ns / 1ps
package rfop_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_BITS = 32;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CAP_W     = 5;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERRUN = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_DATA = 2'd2;

  localparam logic REG_DROP_OLDEST = 1'b0;
  localparam logic REG_CAPACITY    = 1'b1;

  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CAP_W-1:0]     cap_t;
  typedef logic [DATA_BITS-1:0] word_t;

  typedef struct packed {
    logic drop_oldest;
    cap_t capacity_in_use;
  } cfg_t;

  typedef struct packed {
    word_t             pop_data;
    logic [STAT_W-1:0] status;
    logic              is_empty;
    logic              is_full;
  } res_t;

  function automatic cap_t eff_capacity(input cap_t cap);
    cap_t c;
    c = cap;
    if (c < CAP_MIN) begin
      c = CAP_MIN;
    end
    if (c > CAP_MAX) begin
      c = CAP_MAX;
    end
    return c;
  endfunction

  function automatic ptr_t advance(input ptr_t p, input cap_t eff);
    logic [PTR_W:0] n;
    n = {1'b0, p} + (PTR_W+1)'(1);
    if (CAP_W'(n) >= eff) begin
      return '0;
    end
    return n[PTR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/rfop_if.sv =====
// Valid/ready stream interfaces for operation items and result items.
`timescale 1ns / 1ps
interface rfop_in_if;
  import rfop_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [DATA_BITS-1:0] push_data;
  modport source (output valid, output action, output push_data, input ready);
  modport sink   (input valid, input action, input push_data, output ready);
endinterface

interface rfop_out_if;
  import rfop_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] pop_data;
  logic [STAT_W-1:0]    status;
  logic                 is_empty;
  logic                 is_full;
  modport source (output valid, output pop_data, output status, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input pop_data, input status, input is_empty,
                  input is_full, output ready);
endinterface

// ===== hw/rtl/rfop_regs.sv =====
// APB-style configuration registers: drop policy and capacity in use.
`timescale 1ns / 1ps
module rfop_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfop_pkg::APB_AW-1:0]  paddr,
  input  logic [rfop_pkg::APB_DW-1:0]  pwdata,
  output logic [rfop_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output rfop_pkg::cfg_t               cfg
);
  import rfop_pkg::*;

  logic drop_oldest_r;
  cap_t capacity_r;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_oldest_r <= 1'b0;
      capacity_r    <= CAP_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DROP_OLDEST: drop_oldest_r <= pwdata[0];
        REG_CAPACITY:    capacity_r    <= pwdata[CAP_W-1:0];
        default:         drop_oldest_r <= drop_oldest_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DROP_OLDEST: prdata = APB_DW'(drop_oldest_r);
      REG_CAPACITY:    prdata = APB_DW'(capacity_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.drop_oldest     = drop_oldest_r;
  assign cfg.capacity_in_use = capacity_r;

endmodule

// ===== hw/rtl/rfop_ring.sv =====
// Ring store, pointers, the per-item push/pop/flush step and the result register.
`timescale 1ns / 1ps
module rfop_ring (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rfop_pkg::cfg_t                  cfg,
  input  logic                            step_en,
  input  logic [rfop_pkg::ACT_W-1:0]      action,
  input  logic [rfop_pkg::DATA_BITS-1:0]  push_data,
  output rfop_pkg::res_t                  res
);
  import rfop_pkg::*;

  word_t             slot_store [DEPTH];
  ptr_t              wp_r, wp_nxt;
  ptr_t              rp_r, rp_nxt;
  cap_t              eff;
  logic              full_now;
  logic              empty_now;
  logic              store_en;
  logic              pop_en;
  logic [STAT_W-1:0] status_nxt;
  logic              empty_nxt;
  logic              full_nxt;
  res_t              res_r;

  assign eff       = eff_capacity(cfg.capacity_in_use);
  assign full_now  = (advance(wp_r, eff) == rp_r);
  assign empty_now = (wp_r == rp_r);

  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    store_en   = 1'b0;
    pop_en     = 1'b0;
    status_nxt = ST_OK;
    case (action)
      ACT_PUSH: begin
        if (full_now && !cfg.drop_oldest) begin
          status_nxt = ST_OVERRUN;
        end else begin
          if (full_now) begin
            rp_nxt = advance(rp_r, eff);
          end
          store_en = 1'b1;
          wp_nxt   = advance(wp_r, eff);
        end
      end
      ACT_POP: begin
        if (empty_now) begin
          status_nxt = ST_NO_DATA;
        end else begin
          pop_en = 1'b1;
          rp_nxt = advance(rp_r, eff);
        end
      end
      ACT_FLUSH: begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      default: begin
        wp_nxt = wp_r;
      end
    endcase
  end

  assign empty_nxt = (wp_nxt == rp_nxt);
  assign full_nxt  = (advance(wp_nxt, eff) == rp_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else if (step_en) begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      if (store_en) begin
        slot_store[wp_r] <= push_data;
      end
      res_r.pop_data <= pop_en ? slot_store[rp_r] : word_t'(0);
      res_r.status   <= status_nxt;
      res_r.is_empty <= empty_nxt;
      res_r.is_full  <= full_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/ring_fifo_overrun_policy.sv =====
// Top level of the ring FIFO with selectable overrun policy.
// Usage:
//   in_ch carries one operation item per handshake: action (push, pop, flush)
//   and push_data. out_ch returns exactly one result item per operation, in
//   order: pop_data, status, is_empty and is_full after the operation.
//   The cfg_ APB-style port sets drop_oldest (byte address 0) and
//   capacity_in_use (byte address 4); write them only while no item is in
//   flight.
// Timing:
//   An accepted item is held in the input register, then the queue step
//   runs against the pointers and slot store and its result lands in the
//   result register in rfop_ring as out_ch valid rises. One item per cycle
//   is sustained while out_ch is not stalled.
// Reset (rst_n, synchronous, active low):
//   Pointers clear so the queue is empty, drop_oldest clears, capacity_in_use
//   returns to 16, and both stages empty. Slot contents are not cleared.
// Stall:
//   While out_ch is stalled the result holds; one more item may be accepted
//   into the input register, after which in_ch.ready drops until the result
//   is taken.
`timescale 1ns / 1ps
module ring_fifo_overrun_policy (
  input  logic                         clk,
  input  logic                         rst_n,
  rfop_in_if.sink                      in_ch,
  rfop_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rfop_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [rfop_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [rfop_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import rfop_pkg::*;

  cfg_t              cfg;
  res_t              res;
  logic              s1_valid_r;
  logic [ACT_W-1:0]  s1_action_r;
  word_t             s1_data_r;
  logic              out_valid_r;
  logic              out_free;
  logic              step_en;
  logic              in_take;

  rfop_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rfop_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (step_en),
    .action    (s1_action_r),
    .push_data (s1_data_r),
    .res       (res)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign step_en     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_ch.action;
      s1_data_r   <= in_ch.push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.pop_data = res.pop_data;
  assign out_ch.status   = res.status;
  assign out_ch.is_empty = res.is_empty;
  assign out_ch.is_full  = res.is_full;

endmodule

// ===== sim/ring_fifo_overrun_policy_tb.sv =====
// Testbench for the ring FIFO with overrun policy: random and directed items checked against a predictor.
`timescale 1ns / 1ps
module ring_fifo_overrun_policy_tb;
  import rfop_pkg::*;

  localparam logic [ACT_W-1:0]  ACT_NONE         = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_DROP_OLDEST = {REG_DROP_OLDEST, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_CAPACITY    = {REG_CAPACITY, 2'b00};
  localparam int                IDLE_MAX         = 18;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  rfop_in_if  in_if ();
  rfop_out_if out_if ();

  ring_fifo_overrun_policy uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic  drop_mode;
  cap_t  cap_reg;
  ptr_t  wr_ptr;
  ptr_t  rd_ptr;
  word_t slots [DEPTH];
  bit    slot_written [DEPTH];
  res_t  due_results [$];

  int errors      = 0;
  int tx_idle_max = 0;
  int rx_idle_max = 0;
  int hold_req    = 0;

  function automatic ptr_t next_slot(input ptr_t p);
    int lim;
    int n;
    lim = (cap_reg < CAP_MIN) ? int'(CAP_MIN) : ((cap_reg > CAP_MAX) ? DEPTH : int'(cap_reg));
    n = int'(p) + 1;
    return (n >= lim) ? ptr_t'(0) : ptr_t'(n);
  endfunction

  function automatic void ring_step(input logic [ACT_W-1:0] act, input word_t d);
    res_t r;
    logic full;
    r = '0;
    r.status = ST_OK;
    full = (next_slot(wr_ptr) == rd_ptr);
    case (act)
      ACT_PUSH: begin
        if (full && !drop_mode) begin
          r.status = ST_OVERRUN;
        end else begin
          if (full) begin
            rd_ptr = next_slot(rd_ptr);
          end
          slots[wr_ptr] = d;
          slot_written[wr_ptr] = 1'b1;
          wr_ptr = next_slot(wr_ptr);
        end
      end
      ACT_POP: begin
        if (wr_ptr == rd_ptr) begin
          r.status = ST_NO_DATA;
        end else begin
          r.pop_data = slots[rd_ptr];
          rd_ptr = next_slot(rd_ptr);
        end
      end
      ACT_FLUSH: begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
      default: begin
      end
    endcase
    r.is_empty = (wr_ptr == rd_ptr);
    r.is_full  = (next_slot(wr_ptr) == rd_ptr);
    due_results.push_back(r);
  endfunction

  function automatic int pick_idle();
    return ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
  endfunction

  task automatic send_op(input logic [ACT_W-1:0] act, input word_t d);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.push_data <= d;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    ring_step(act, d);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic drop, input cap_t cap);
    drain();
    cfg_write(ADDR_DROP_OLDEST, APB_DW'(drop));
    cfg_write(ADDR_CAPACITY, APB_DW'(cap));
    drop_mode = drop;
    cap_reg   = cap;
  endtask

  task automatic run_traffic(input int count, input int push_pct, input int tx_max,
                             input int rx_max);
    int               roll;
    logic [ACT_W-1:0] act;
    word_t            d;
    tx_idle_max = tx_max;
    rx_idle_max = rx_max;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        act = ACT_FLUSH;
      end else if (roll < 5) begin
        act = ACT_NONE;
      end else if (roll < 5 + push_pct) begin
        act = ACT_PUSH;
      end else begin
        act = ACT_POP;
      end
      // steer away from popping a slot that was never written
      if (act == ACT_POP && wr_ptr != rd_ptr && !slot_written[rd_ptr]) begin
        act = ACT_PUSH;
      end
      case ($urandom_range(0, 9))
        0: d = '0;
        1: d = '1;
        default: d = $urandom;
      endcase
      send_op(act, d);
    end
  endtask

  task automatic test_directed();
    tx_idle_max = pick_idle();
    rx_idle_max = pick_idle();
    send_op(ACT_POP, 32'h0000_0000);
    set_mode(1'b0, 5'd3);
    send_op(ACT_PUSH, 32'h0000_0000);
    send_op(ACT_PUSH, 32'hFFFF_FFFF);
    send_op(ACT_PUSH, 32'h1234_5678);
    send_op(ACT_POP, 32'hFFFF_FFFF);
    send_op(ACT_NONE, 32'hFFFF_FFFF);
    send_op(ACT_POP, 32'h0000_0000);
    send_op(ACT_POP, 32'h0000_0000);
    send_op(ACT_PUSH, 32'hAAAA_AAAA);
    send_op(ACT_FLUSH, 32'h5555_5555);
    send_op(ACT_POP, 32'h0000_0000);
    set_mode(1'b1, 5'd3);
    send_op(ACT_PUSH, 32'h0000_0001);
    send_op(ACT_PUSH, 32'h0000_0002);
    send_op(ACT_PUSH, 32'h0000_0003);
    send_op(ACT_POP, 32'h0000_0000);
    send_op(ACT_POP, 32'h0000_0000);
    send_op(ACT_POP, 32'h0000_0000);
    set_mode(1'b1, CAP_MIN);
    send_op(ACT_PUSH, 32'h5555_5555);
    send_op(ACT_PUSH, 32'hA5A5_A5A5);
    send_op(ACT_POP, 32'h0000_0000);
  endtask

  task automatic test_refuse_policy();
    cap_t caps [4];
    caps = '{CAP_MIN, CAP_MAX, 5'd5, cap_t'($urandom_range(2, 16))};
    foreach (caps[k]) begin
      set_mode(1'b0, caps[k]);
      run_traffic(150, (k % 2 == 0) ? 70 : 35, pick_idle(), pick_idle());
    end
  endtask

  task automatic test_drop_policy();
    cap_t caps [4];
    caps = '{CAP_MAX, CAP_MIN, 5'd7, cap_t'($urandom_range(2, 16))};
    foreach (caps[k]) begin
      set_mode(1'b1, caps[k]);
      run_traffic(150, (k % 2 == 0) ? 70 : 35, pick_idle(), pick_idle());
    end
  endtask

  task automatic test_capacity_clamp();
    set_mode(1'b0, 5'd0);
    run_traffic(60, 60, pick_idle(), pick_idle());
    set_mode(1'b1, 5'd1);
    run_traffic(60, 60, pick_idle(), pick_idle());
    set_mode(1'b0, 5'd31);
    run_traffic(60, 60, pick_idle(), pick_idle());
    set_mode(1'b1, 5'd17);
    run_traffic(60, 60, pick_idle(), pick_idle());
  endtask

  task automatic test_resize_with_data();
    set_mode(1'b0, 5'd6);
    send_op(ACT_FLUSH, '0);
    run_traffic(80, 75, pick_idle(), pick_idle());
    set_mode(1'b0, 5'd14);
    run_traffic(55, 45, pick_idle(), pick_idle());
    set_mode(1'b1, 5'd3);
    run_traffic(50, 50, pick_idle(), pick_idle());
    set_mode(1'b1, CAP_MAX);
    run_traffic(50, 40, pick_idle(), pick_idle());
  endtask

  task automatic test_backpressure();
    set_mode(1'b1, CAP_MAX);
    hold_req = 80;
    run_traffic(50, 60, 0, 0);
    drain();
    set_mode(1'b0, 5'd4);
    hold_req = 60;
    run_traffic(50, 70, 0, IDLE_MAX);
    drain();
  endtask

  initial begin : result_check
    int   gap;
    res_t want;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = $urandom_range(0, rx_idle_max);
      if (hold_req > 0) begin
        gap = hold_req;
        hold_req = 0;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1)) @(posedge clk);
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: data %h status %0d empty %b full %b",
                   out_if.pop_data, out_if.status, out_if.is_empty, out_if.is_full);
        end
      end else begin
        want = due_results.pop_front();
        if (out_if.pop_data !== want.pop_data || out_if.status !== want.status ||
            out_if.is_empty !== want.is_empty || out_if.is_full !== want.is_full) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected data %h status %0d empty %b full %b",
                     want.pop_data, want.status, want.is_empty, want.is_full);
            $display("          got      data %h status %0d empty %b full %b",
                     out_if.pop_data, out_if.status, out_if.is_empty, out_if.is_full);
          end
        end
      end
    end
  end

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.action    <= ACT_PUSH;
    in_if.push_data <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    drop_mode = 1'b0;
    cap_reg   = CAP_RESET;
    wr_ptr    = '0;
    rd_ptr    = '0;
    foreach (slot_written[k]) slot_written[k] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_refuse_policy();
    test_drop_policy();
    test_capacity_clamp();
    test_resize_with_data();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);
    errors += due_results.size();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
